// ----- src/dwc_pkg.sv -----
`default_nettype none

package dwc_pkg;

    localparam int CP_W              = 21;
    localparam int TOTAL_W           = 16;
    localparam int DEFAULT_COUNT_BITS = 16;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_VIRAMA      = 21'h0009CD;
    localparam logic [CP_W-1:0] CP_STACKER     = 21'h001039;

    // One queue entry: up to two code points produced by one byte, plus end of string
    typedef struct packed {
        logic            last;
        logic            cp0_valid;
        logic [CP_W-1:0] cp0;
        logic            cp1_valid;
        logic [CP_W-1:0] cp1;
    } dwc_item_t;

    function automatic logic in_rng(input logic [CP_W-1:0] c,
                                    input logic [CP_W-1:0] lo,
                                    input logic [CP_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic [1:0] cp_width(input logic [CP_W-1:0] c);
        logic zero_w;
        logic wide_w;
        zero_w = (c == 21'h0) || (c == 21'h200B) || (c == 21'h200C) || (c == 21'h200D)
              || (c == 21'hFEFF) || (c < 21'h20) || in_rng(c, 21'h7F, 21'h9F)
              || in_rng(c, 21'h0300, 21'h036F) || (c == 21'h0901) || (c == 21'h0902)
              || (c == 21'h093C) || in_rng(c, 21'h0941, 21'h0948) || (c == 21'h094D)
              || (c == 21'h0981) || (c == 21'h09BC) || in_rng(c, 21'h09C1, 21'h09C4)
              || (c == 21'h09CD) || in_rng(c, 21'h09E2, 21'h09E3) || (c == 21'h0E31)
              || in_rng(c, 21'h0E34, 21'h0E3A) || in_rng(c, 21'h0E47, 21'h0E4E)
              || in_rng(c, 21'h102D, 21'h1030) || in_rng(c, 21'h1032, 21'h1037)
              || in_rng(c, 21'h1039, 21'h103A) || in_rng(c, 21'h103D, 21'h103E)
              || in_rng(c, 21'h1DC0, 21'h1DFF) || in_rng(c, 21'h20D0, 21'h20FF)
              || in_rng(c, 21'hFE20, 21'hFE2F);
        wide_w = in_rng(c, 21'h1100, 21'h115F) || (c == 21'h2329) || (c == 21'h232A)
              || in_rng(c, 21'h2E80, 21'h303E) || in_rng(c, 21'h3040, 21'h33FF)
              || in_rng(c, 21'h3400, 21'h4DBF) || in_rng(c, 21'h4E00, 21'h9FFF)
              || in_rng(c, 21'hA000, 21'hA4CF) || in_rng(c, 21'hA960, 21'hA97F)
              || in_rng(c, 21'hAC00, 21'hD7AF) || in_rng(c, 21'hF900, 21'hFAFF)
              || in_rng(c, 21'hFE10, 21'hFE19) || in_rng(c, 21'hFE30, 21'hFE4F)
              || in_rng(c, 21'hFF00, 21'hFF60) || in_rng(c, 21'hFFE0, 21'hFFE6)
              || in_rng(c, 21'h1B000, 21'h1B0FF) || in_rng(c, 21'h1F300, 21'h1F9FF)
              || in_rng(c, 21'h20000, 21'h2FFFD) || in_rng(c, 21'h30000, 21'h3FFFD);
        if (zero_w)
            return 2'd0;
        else if (wide_w)
            return 2'd2;
        else
            return 2'd1;
    endfunction

endpackage

`default_nettype wire

// ----- src/display_width_counter_top.sv -----
`default_nettype none

// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------
// byte     | byte_valid / byte_ready   | byte_value[7:0], last_byte
// total    | total_valid / total_ready | total_columns[15:0], width_saturated
//
// One byte per cycle, while byte_ready is high, enters the UTF-8/escape parser;
// a four-entry queue feeds the width unit, which settles up to two code points
// per entry; total_valid is registered when the last entry is popped.
// rst_n clears parser state, queue and running count; no clearing pass.
// byte_ready drops only while the queue is full; the queue fills when totals
// are held back by total_ready.

module display_width_counter_top #(
    parameter int COUNT_BITS = dwc_pkg::DEFAULT_COUNT_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      byte_valid,
    output logic                           byte_ready,
    input  wire logic [7:0]                byte_value,
    input  wire logic                      last_byte,
    output logic                           total_valid,
    input  wire logic                      total_ready,
    output logic [dwc_pkg::TOTAL_W-1:0]    total_columns,
    output logic                           width_saturated
);
    import dwc_pkg::*;

    dwc_item_t push_item;
    dwc_item_t head_item;
    logic      q_push, q_full, q_pop, q_empty;

    dwc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    dwc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    dwc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_head          (head_item),
        .q_pop           (q_pop),
        .total_valid     (total_valid),
        .total_ready     (total_ready),
        .total_columns   (total_columns),
        .width_saturated (width_saturated)
    );

endmodule

`default_nettype wire

// ----- src/dwc_front.sv -----
`default_nettype none

module dwc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             byte_valid,
    output logic                  byte_ready,
    input  wire logic [7:0]       byte_value,
    input  wire logic             last_byte,
    input  wire logic             q_full,
    output logic                  q_push,
    output dwc_pkg::dwc_item_t    q_item
);
    import dwc_pkg::*;

    typedef enum logic [5:0] {
        MODE_START    = 6'b000001,
        MODE_ESC      = 6'b000010,
        MODE_CSI      = 6'b000100,
        MODE_MULTI    = 6'b001000,
        MODE_SKIPCONT = 6'b010000,
        MODE_ENDED    = 6'b100000
    } mode_t;

    typedef struct packed {
        mode_t           mode;
        logic [1:0]      need;
        logic [CP_W-1:0] acc;
        logic            ev_valid;
        logic [CP_W-1:0] ev_cp;
    } start_t;

    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_ESC = 8'h1B;
    localparam logic [7:0] BYTE_LBR = 8'h5B;
    localparam logic [7:0] BYTE_M   = 8'h6D;

    mode_t           mode_reg, mode_next;
    logic [1:0]      need_reg, need_next;
    logic [CP_W-1:0] acc_reg, acc_next;

    function automatic start_t char_start(input logic [7:0] b,
                                          input logic [1:0] need,
                                          input logic [CP_W-1:0] acc);
        start_t r;
        r.mode     = MODE_START;
        r.need     = need;
        r.acc      = acc;
        r.ev_valid = 1'b0;
        r.ev_cp    = CP_REPLACEMENT;
        if (b == BYTE_NUL) begin
            r.mode = MODE_ENDED;
        end else if (b == BYTE_ESC) begin
            r.mode = MODE_ESC;
        end else if (!b[7]) begin
            r.ev_valid = 1'b1;
            r.ev_cp    = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
            r.acc  = {16'd0, b[4:0]};
            r.need = 2'd1;
            r.mode = MODE_MULTI;
        end else if (b[7:4] == 4'b1110) begin
            r.acc  = {17'd0, b[3:0]};
            r.need = 2'd2;
            r.mode = MODE_MULTI;
        end else if (b[7:3] == 5'b11110) begin
            r.acc  = {18'd0, b[2:0]};
            r.need = 2'd3;
            r.mode = MODE_MULTI;
        end else begin
            // stray continuation or bad lead
            r.ev_valid = 1'b1;
            r.mode     = MODE_SKIPCONT;
        end
        return r;
    endfunction

    start_t          cs;
    logic            cont;
    logic            broken;
    logic            ev_valid;
    logic [CP_W-1:0] ev_cp;
    logic            trunc;
    logic [CP_W-1:0] acc_sh;
    logic            accept;

    always_comb
    begin
        cont      = (byte_value[7:6] == 2'b10);
        cs        = char_start(byte_value, need_reg, acc_reg);
        acc_sh    = {acc_reg[CP_W-7:0], byte_value[5:0]};
        mode_next = mode_reg;
        need_next = need_reg;
        acc_next  = acc_reg;
        broken    = 1'b0;
        ev_valid  = 1'b0;
        ev_cp     = CP_REPLACEMENT;
        unique case (mode_reg)
            MODE_CSI:
            begin
                if (byte_value == BYTE_NUL)
                    mode_next = MODE_ENDED;
                else if (byte_value == BYTE_M)
                    mode_next = MODE_START;
            end
            MODE_ESC:
            begin
                if (byte_value == BYTE_LBR) begin
                    mode_next = MODE_CSI;
                end else begin
                    mode_next = cs.mode;
                    need_next = cs.need;
                    acc_next  = cs.acc;
                    ev_valid  = cs.ev_valid;
                    ev_cp     = cs.ev_cp;
                end
            end
            MODE_MULTI:
            begin
                if (cont) begin
                    acc_next  = acc_sh;
                    need_next = need_reg - 2'd1;
                    if (need_reg == 2'd1) begin
                        if (acc_sh == '0) begin
                            mode_next = MODE_ENDED;
                        end else begin
                            mode_next = MODE_START;
                            ev_valid  = 1'b1;
                            ev_cp     = acc_sh;
                        end
                    end
                end else begin
                    // broken sequence: one replacement, then the byte starts afresh
                    broken    = 1'b1;
                    mode_next = cs.mode;
                    need_next = cs.need;
                    acc_next  = cs.acc;
                    ev_valid  = cs.ev_valid;
                    ev_cp     = cs.ev_cp;
                end
            end
            MODE_SKIPCONT, MODE_START:
            begin
                if (!(cont && mode_reg == MODE_SKIPCONT)) begin
                    mode_next = cs.mode;
                    need_next = cs.need;
                    acc_next  = cs.acc;
                    ev_valid  = cs.ev_valid;
                    ev_cp     = cs.ev_cp;
                end
            end
            MODE_ENDED:
            begin
                mode_next = mode_reg;
            end
            default:
            begin
                mode_next = MODE_START;
            end
        endcase

        trunc = last_byte && (mode_next == MODE_MULTI);

        q_item.last = last_byte;
        if (broken) begin
            q_item.cp0_valid = 1'b1;
            q_item.cp0       = CP_REPLACEMENT;
            q_item.cp1_valid = ev_valid || trunc;
            q_item.cp1       = ev_valid ? ev_cp : CP_REPLACEMENT;
        end else begin
            q_item.cp0_valid = ev_valid || trunc;
            q_item.cp0       = ev_valid ? ev_cp : CP_REPLACEMENT;
            q_item.cp1_valid = 1'b0;
            q_item.cp1       = CP_REPLACEMENT;
        end
    end

    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;
    assign q_push     = accept && (q_item.cp0_valid || last_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_START;
            need_reg <= 2'd0;
            acc_reg  <= '0;
        end else if (accept) begin
            if (last_byte) begin
                mode_reg <= MODE_START;
                need_reg <= 2'd0;
                acc_reg  <= '0;
            end else begin
                mode_reg <= mode_next;
                need_reg <= need_next;
                acc_reg  <= acc_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/dwc_fifo.sv -----
`default_nettype none

module dwc_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire dwc_pkg::dwc_item_t  push_item,
    output logic                     full,
    input  wire logic                pop,
    output dwc_pkg::dwc_item_t       head_item,
    output logic                     empty
);
    import dwc_pkg::*;

    dwc_item_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push, do_pop;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + FIFO_CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - FIFO_CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- src/dwc_back.sv -----
`default_nettype none

module dwc_back #(
    parameter int COUNT_BITS = dwc_pkg::DEFAULT_COUNT_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire dwc_pkg::dwc_item_t           q_head,
    output logic                              q_pop,
    output logic                              total_valid,
    input  wire logic                         total_ready,
    output logic [dwc_pkg::TOTAL_W-1:0]       total_columns,
    output logic                              width_saturated
);
    import dwc_pkg::*;

    localparam logic [COUNT_BITS:0] COUNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  sat_reg, sat_next;
    logic                  stk_reg, stk_next;
    logic                  out_valid_reg;
    logic [TOTAL_W-1:0]    out_total_reg;
    logic                  out_sat_reg;

    logic [1:0]            w0, w1, w0_eff, w1_eff;
    logic                  stk_mid;
    logic [COUNT_BITS:0]   sum;
    logic [TOTAL_W-1:0]    total_trim;

    assign q_pop = !q_empty && (!q_head.last || !out_valid_reg || total_ready);

    always_comb
    begin
        w0      = cp_width(q_head.cp0);
        w1      = cp_width(q_head.cp1);
        stk_mid = stk_reg;
        w0_eff  = 2'd0;
        w1_eff  = 2'd0;
        // a width-1 character after a virama or stacker collapses to zero
        if (q_head.cp0_valid) begin
            w0_eff = w0;
            if (stk_reg && w0 == 2'd1) begin
                w0_eff  = 2'd0;
                stk_mid = 1'b0;
            end else if (q_head.cp0 == CP_VIRAMA || q_head.cp0 == CP_STACKER) begin
                stk_mid = 1'b1;
            end
        end
        stk_next = stk_mid;
        if (q_head.cp1_valid) begin
            w1_eff = w1;
            if (stk_mid && w1 == 2'd1) begin
                w1_eff   = 2'd0;
                stk_next = 1'b0;
            end else if (q_head.cp1 == CP_VIRAMA || q_head.cp1 == CP_STACKER) begin
                stk_next = 1'b1;
            end
        end

        sum        = {1'b0, total_reg} + (COUNT_BITS+1)'(w0_eff) + (COUNT_BITS+1)'(w1_eff);
        total_next = total_reg;
        sat_next   = sat_reg;
        // reaching the maximum, even by a zero-width add, flags saturation
        if (q_head.cp0_valid) begin
            if (sum >= COUNT_MAX) begin
                total_next = COUNT_MAX[COUNT_BITS-1:0];
                sat_next   = 1'b1;
            end else begin
                total_next = sum[COUNT_BITS-1:0];
            end
        end

        total_trim = TOTAL_W'(total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            stk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                if (q_head.last) begin
                    total_reg <= '0;
                    sat_reg   <= 1'b0;
                    stk_reg   <= 1'b0;
                end else begin
                    total_reg <= total_next;
                    sat_reg   <= sat_next;
                    stk_reg   <= stk_next;
                end
            end
            if (q_pop && q_head.last)
                out_valid_reg <= 1'b1;
            else if (total_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.last) begin
            out_total_reg <= total_trim;
            out_sat_reg   <= sat_next;
        end
    end

    assign total_valid     = out_valid_reg;
    assign total_columns   = out_total_reg;
    assign width_saturated = out_sat_reg;

endmodule

`default_nettype wire

// ----- tb/sv/display_width_counter_top_test.sv -----
`default_nettype none

module display_width_counter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dwc_pkg::*;

    localparam int COUNT_BITS = DEFAULT_COUNT_BITS;
    localparam longint unsigned COLUMN_MAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam int RANDOM_BYTES = 1750;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER_TOTALS = 12;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_PRINTED = 40;
    localparam int GAP_MAX = 13;
    localparam int BOUNDARY_COUNT = 44;

    localparam logic [7:0] NUL_BYTE = 8'h00;
    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] CSI_OPEN = 8'h5B;
    localparam logic [7:0] CSI_FINAL = 8'h6D;
    localparam logic [7:0] DEL_BYTE = 8'h7F;

    typedef enum logic [2:0] {
        SCAN_CHAR,
        SCAN_ESC,
        SCAN_CSI,
        SCAN_MULTI,
        SCAN_SKIP,
        SCAN_DONE
    } scan_mode_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
        int         gap;
    } text_byte_t;

    typedef struct {
        logic [TOTAL_W-1:0] columns;
        logic               saturated;
    } string_width_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic [7:0] byte_value = 8'h00;
    logic last_byte = 1'b0;
    logic total_ready = 1'b0;
    logic hold_off = 1'b0;
    wire logic byte_ready;
    wire logic total_valid;
    wire logic [TOTAL_W-1:0] total_columns;
    wire logic width_saturated;

    text_byte_t pending_bytes[$];
    string_width_t expected_widths[$];
    logic [7:0] text_buf[$];
    text_byte_t next_byte;

    // width predictor state
    scan_mode_t scan_mode = SCAN_CHAR;
    logic [1:0] scan_pending = 2'd0;
    logic [CP_W-1:0] scan_cp = '0;
    logic stack_armed = 1'b0;
    longint unsigned col_count = 0;
    logic col_full = 1'b0;

    int sender_wait = 0;
    int receiver_wait = 0;
    bit rx_calm = 1'b0;
    int cycle_count = 0;
    int error_count = 0;
    int bytes_accepted = 0;
    int totals_checked = 0;
    int saturated_seen = 0;
    int random_bytes = 0;
    int strings_queued = 0;

    display_width_counter_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .byte_value      (byte_value),
        .last_byte       (last_byte),
        .total_valid     (total_valid),
        .total_ready     (total_ready),
        .total_columns   (total_columns),
        .width_saturated (width_saturated)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // ---------------------------------------------------------------- predictor

    function automatic bit between(logic [CP_W-1:0] c, logic [CP_W-1:0] lo,
                                   logic [CP_W-1:0] hi);
        return c >= lo && c <= hi;
    endfunction

    function automatic int glyph_columns(logic [CP_W-1:0] c);
        bit combining;
        bit wide;
        if (c < 21'h20 || between(c, 21'h7F, 21'h9F) || c == 21'h200B || c == 21'h200C
            || c == 21'h200D || c == 21'hFEFF)
            return 0;
        combining = between(c, 21'h0300, 21'h036F) || between(c, 21'h0901, 21'h0902)
            || c == 21'h093C || between(c, 21'h0941, 21'h0948) || c == 21'h094D
            || c == 21'h0981 || c == 21'h09BC || between(c, 21'h09C1, 21'h09C4)
            || c == 21'h09CD || between(c, 21'h09E2, 21'h09E3) || c == 21'h0E31
            || between(c, 21'h0E34, 21'h0E3A) || between(c, 21'h0E47, 21'h0E4E)
            || between(c, 21'h102D, 21'h1030) || between(c, 21'h1032, 21'h1037)
            || between(c, 21'h1039, 21'h103A) || between(c, 21'h103D, 21'h103E)
            || between(c, 21'h1DC0, 21'h1DFF) || between(c, 21'h20D0, 21'h20FF)
            || between(c, 21'hFE20, 21'hFE2F);
        if (combining)
            return 0;
        wide = between(c, 21'h1100, 21'h115F) || between(c, 21'h2329, 21'h232A)
            || between(c, 21'h2E80, 21'h303E) || between(c, 21'h3040, 21'h4DBF)
            || between(c, 21'h4E00, 21'hA4CF) || between(c, 21'hA960, 21'hA97F)
            || between(c, 21'hAC00, 21'hD7AF) || between(c, 21'hF900, 21'hFAFF)
            || between(c, 21'hFE10, 21'hFE19) || between(c, 21'hFE30, 21'hFE4F)
            || between(c, 21'hFF00, 21'hFF60) || between(c, 21'hFFE0, 21'hFFE6)
            || between(c, 21'h1B000, 21'h1B0FF) || between(c, 21'h1F300, 21'h1F9FF)
            || between(c, 21'h20000, 21'h2FFFD) || between(c, 21'h30000, 21'h3FFFD);
        return wide ? 2 : 1;
    endfunction

    task automatic add_glyph(input logic [CP_W-1:0] c);
        int w;
        if (c == '0)
            scan_mode = SCAN_DONE;
        else
        begin
            w = glyph_columns(c);
            if (stack_armed && w == 1)
            begin
                w = 0;
                stack_armed = 1'b0;
            end
            else if (c == CP_VIRAMA || c == CP_STACKER)
                stack_armed = 1'b1;
            if (longint'(w) >= COLUMN_MAX - col_count)
            begin
                col_count = COLUMN_MAX;
                col_full = 1'b1;
            end
            else
                col_count = col_count + w;
        end
    endtask

    task automatic begin_char(input logic [7:0] b);
        scan_mode = SCAN_CHAR;
        if (b == NUL_BYTE)
            scan_mode = SCAN_DONE;
        else if (b == ESC_BYTE)
            scan_mode = SCAN_ESC;
        else if (b < 8'h80)
            add_glyph(CP_W'(b));
        else if (b[7:5] == 3'b110)
        begin
            scan_cp = CP_W'(b[4:0]);
            scan_pending = 2'd1;
            scan_mode = SCAN_MULTI;
        end
        else if (b[7:4] == 4'b1110)
        begin
            scan_cp = CP_W'(b[3:0]);
            scan_pending = 2'd2;
            scan_mode = SCAN_MULTI;
        end
        else if (b[7:3] == 5'b11110)
        begin
            scan_cp = CP_W'(b[2:0]);
            scan_pending = 2'd3;
            scan_mode = SCAN_MULTI;
        end
        else
        begin
            // stray continuation or invalid lead: one replacement, then eat continuations
            add_glyph(CP_REPLACEMENT);
            scan_mode = SCAN_SKIP;
        end
    endtask

    task automatic measure_byte(input logic [7:0] b, input logic last);
        string_width_t res;
        case (scan_mode)
            SCAN_CSI:
                if (b == NUL_BYTE)
                    scan_mode = SCAN_DONE;
                else if (b == CSI_FINAL)
                    scan_mode = SCAN_CHAR;
            SCAN_ESC:
                if (b == CSI_OPEN)
                    scan_mode = SCAN_CSI;
                else
                    begin_char(b);
            SCAN_MULTI:
                if (b[7:6] == 2'b10)
                begin
                    scan_cp = {scan_cp[CP_W-7:0], b[5:0]};
                    scan_pending = scan_pending - 2'd1;
                    if (scan_pending == 2'd0)
                    begin
                        scan_mode = SCAN_CHAR;
                        add_glyph(scan_cp);
                    end
                end
                else
                begin
                    // broken sequence: replacement, then the byte starts afresh
                    scan_pending = 2'd0;
                    scan_mode = SCAN_CHAR;
                    add_glyph(CP_REPLACEMENT);
                    begin_char(b);
                end
            SCAN_SKIP:
                if (b[7:6] != 2'b10)
                    begin_char(b);
            SCAN_CHAR:
                begin_char(b);
            default:
                ;
        endcase
        if (last)
        begin
            if (scan_mode == SCAN_MULTI)
            begin
                scan_mode = SCAN_CHAR;
                add_glyph(CP_REPLACEMENT);
            end
            res.columns = col_count[TOTAL_W-1:0];
            res.saturated = col_full;
            expected_widths.push_back(res);
            scan_mode = SCAN_CHAR;
            scan_pending = 2'd0;
            scan_cp = '0;
            stack_armed = 1'b0;
            col_count = 0;
            col_full = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_total(input logic [TOTAL_W-1:0] cols, input logic sat);
        string_width_t want;
        if (expected_widths.size() == 0)
            report_mismatch($sformatf("total %0d sat %0b with no string outstanding", cols, sat));
        else
        begin
            want = expected_widths.pop_front();
            totals_checked++;
            if (want.saturated)
                saturated_seen++;
            if (cols !== want.columns)
                report_mismatch($sformatf("string %0d: total_columns %0d, expected %0d",
                                          totals_checked, cols, want.columns));
            if (sat !== want.saturated)
                report_mismatch($sformatf("string %0d: width_saturated %0b, expected %0b",
                                          totals_checked, sat, want.saturated));
        end
    endtask

    // ---------------------------------------------------------------- driver and monitor

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                measure_byte(byte_value, last_byte);
                bytes_accepted++;
            end
            if (!byte_valid || byte_ready)
            begin
                if (sender_wait > 0)
                begin
                    sender_wait--;
                    byte_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_byte = pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                    byte_value <= next_byte.value;
                    last_byte <= next_byte.last;
                    sender_wait = next_byte.gap;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (total_valid && total_ready)
            begin
                check_total(total_columns, width_saturated);
                if ($urandom_range(0, 7) == 0)
                    rx_calm = !rx_calm;
                receiver_wait = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (hold_off)
                total_ready <= 1'b0;
            else if (receiver_wait > 0)
            begin
                receiver_wait--;
                total_ready <= 1'b0;
            end
            else
                total_ready <= 1'b1;
        end
    end

    // long back-pressure so the internal queue fills and byte_ready drops
    initial
    begin
        while (totals_checked < HOLD_AFTER_TOTALS)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [CP_W-1:0] boundary_cp(int k);
        case (k)
            0:  return 21'h00009F;
            1:  return 21'h0000A0;
            2:  return 21'h0002FF;
            3:  return 21'h000300;
            4:  return 21'h00036F;
            5:  return 21'h000370;
            6:  return 21'h000902;
            7:  return 21'h00094D;
            8:  return 21'h0009BC;
            9:  return 21'h0009C4;
            10: return 21'h0009E3;
            11: return 21'h000E31;
            12: return 21'h000E3A;
            13: return 21'h000E4E;
            14: return 21'h001030;
            15: return 21'h001037;
            16: return 21'h00103A;
            17: return 21'h00103E;
            18: return 21'h001100;
            19: return 21'h00115F;
            20: return 21'h001DC0;
            21: return 21'h00200B;
            22: return 21'h00200D;
            23: return 21'h0020D0;
            24: return 21'h00232A;
            25: return 21'h002E80;
            26: return 21'h00303E;
            27: return 21'h004DBF;
            28: return 21'h004E00;
            29: return 21'h00A4CF;
            30: return 21'h00A960;
            31: return 21'h00AC00;
            32: return 21'h00D7AF;
            33: return 21'h00F900;
            34: return 21'h00FE10;
            35: return 21'h00FE2F;
            36: return 21'h00FE4F;
            37: return 21'h00FEFF;
            38: return 21'h00FF60;
            39: return 21'h00FFE6;
            40: return 21'h01B0FF;
            41: return 21'h01F9FF;
            42: return 21'h02FFFD;
            default: return 21'h03FFFD;
        endcase
    endfunction

    function automatic int utf8_length(logic [CP_W-1:0] c);
        if (c < 21'h80)
            return 1;
        else if (c < 21'h800)
            return 2;
        else if (c < 21'h10000)
            return 3;
        return 4;
    endfunction

    task automatic put_raw(input logic [7:0] b);
        text_buf.push_back(b);
    endtask

    // n may exceed the natural length to give an overlong form
    task automatic put_utf8(input logic [CP_W-1:0] c, input int n);
        case (n)
            1: put_raw({1'b0, c[6:0]});
            2:
            begin
                put_raw({3'b110, c[10:6]});
                put_raw({2'b10, c[5:0]});
            end
            3:
            begin
                put_raw({4'b1110, c[15:12]});
                put_raw({2'b10, c[11:6]});
                put_raw({2'b10, c[5:0]});
            end
            default:
            begin
                put_raw({5'b11110, c[20:18]});
                put_raw({2'b10, c[17:12]});
                put_raw({2'b10, c[11:6]});
                put_raw({2'b10, c[5:0]});
            end
        endcase
    endtask

    task automatic flush_text(input int gap_max, input bit counted);
        text_byte_t t;
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++)
        begin
            t.value = text_buf[i];
            t.last = (i == n - 1);
            t.gap = $urandom_range(0, gap_max);
            pending_bytes.push_back(t);
        end
        if (counted)
            random_bytes += n;
        if (n > 0)
            strings_queued++;
        text_buf.delete();
    endtask

    function automatic logic [CP_W-1:0] pick_cp();
        logic [CP_W-1:0] c;
        case ($urandom_range(0, 3))
            0: c = CP_W'($urandom_range(21'h80, 21'hFFFF));
            1: c = CP_W'($urandom_range(0, 21'h1FFFFF));
            default:
            begin
                c = boundary_cp($urandom_range(0, BOUNDARY_COUNT - 1));
                c = c + CP_W'($urandom_range(0, 2)) - CP_W'(1);
            end
        endcase
        return c;
    endfunction

    task automatic add_fragment();
        logic [CP_W-1:0] c;
        int n;
        int k;
        k = $urandom_range(0, 19);
        if (k <= 4)
            put_raw(8'($urandom_range(8'h20, 8'h7E)));
        else if (k == 5)
            put_raw(8'($urandom_range(8'h01, 8'h1F)));
        else if (k <= 7)
        begin
            put_raw(ESC_BYTE);
            put_raw(CSI_OPEN);
            repeat ($urandom_range(0, 3))
                put_raw($urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255))
                                                  : 8'($urandom_range(8'h30, 8'h3F)));
            if ($urandom_range(0, 7) != 0)
                put_raw(CSI_FINAL);
        end
        else if (k == 8)
        begin
            put_raw(ESC_BYTE);
            put_raw(8'($urandom_range(1, 255)));
        end
        else if (k <= 12)
        begin
            c = pick_cp();
            put_utf8(c, utf8_length(c));
        end
        else if (k == 13)
        begin
            // natural or overlong encodings, the zero code point among them
            c = $urandom_range(0, 1) ? CP_W'($urandom_range(0, 8'h7F)) : pick_cp();
            n = utf8_length(c);
            put_utf8(c, $urandom_range(n, 4));
        end
        else if (k == 14)
        begin
            put_utf8($urandom_range(0, 1) ? CP_VIRAMA : CP_STACKER, 3);
            if ($urandom_range(0, 1))
                put_raw(8'($urandom_range(8'h21, 8'h7E)));
            else
            begin
                c = pick_cp();
                put_utf8(c, utf8_length(c));
            end
        end
        else if (k == 15)
        begin
            // lead byte followed by too few continuations
            n = $urandom_range(2, 4);
            c = CP_W'($urandom_range(0, 21'h1FFFFF));
            case (n)
                2: put_raw({3'b110, c[4:0]});
                3: put_raw({4'b1110, c[3:0]});
                default: put_raw({5'b11110, c[2:0]});
            endcase
            repeat ($urandom_range(0, n - 2))
                put_raw(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (k <= 17)
            put_raw(8'($urandom_range(1, 255)));
        else if (k == 18)
            repeat ($urandom_range(1, 3))
                put_raw(8'($urandom_range(8'h80, 8'hBF)));
        else
            put_raw($urandom_range(0, 3) == 0 ? NUL_BYTE : DEL_BYTE);
    endtask

    task automatic build_stimulus();
        int frags;
        int gap_max;
        // directed strings
        put_raw(NUL_BYTE);
        flush_text(GAP_MAX, 0);
        put_raw(8'hFF);
        flush_text(GAP_MAX, 0);
        // NUL inside a control sequence ends counting
        put_raw(ESC_BYTE); put_raw(CSI_OPEN); put_raw(NUL_BYTE); put_raw(8'h41);
        flush_text(GAP_MAX, 0);
        put_raw(ESC_BYTE); put_raw(8'h41); put_raw(ESC_BYTE); put_raw(CSI_OPEN);
        put_raw(CSI_FINAL); put_raw(DEL_BYTE);
        flush_text(GAP_MAX, 0);
        // virama stacks the next letter, broken lead, stray continuation
        put_utf8(CP_VIRAMA, 3); put_raw(8'h61); put_raw(8'hC3); put_raw(8'h62);
        put_raw(8'h80);
        flush_text(GAP_MAX, 0);
        // wide emoji, then a sequence cut short by the end of the string
        put_utf8(21'h1F300, 4); put_raw(8'hE4); put_raw(8'hB8);
        flush_text(GAP_MAX, 0);
        put_raw(8'h61); put_raw(ESC_BYTE);
        flush_text(GAP_MAX, 0);

        while (random_bytes < RANDOM_BYTES)
        begin
            frags = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 100)
                                                 : $urandom_range(1, 8);
            repeat (frags) add_fragment();
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            flush_text(gap_max, 1);
        end
    endtask

    // ---------------------------------------------------------------- run control

    initial
    begin
        build_stimulus();
        while (!(pending_bytes.size() == 0 && !byte_valid && expected_widths.size() == 0)
               && cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        if (cycle_count < CYCLE_LIMIT)
            repeat (SETTLE_CYCLES) @(posedge clk);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d totals outstanding",
                     cycle_count, expected_widths.size());
            $display("** display_width_counter_top: FAILED **");
        end
        else
        begin
            $display("%0d bytes in %0d strings (%0d random), %0d totals checked",
                     bytes_accepted, strings_queued, random_bytes, totals_checked);
            $display("%0d saturated totals, %0d mismatches, %0d cycles",
                     saturated_seen, error_count, cycle_count);
            if (error_count == 0 && expected_widths.size() == 0)
                $display("** display_width_counter_top: PASSED **");
            else
                $display("** display_width_counter_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
